### rtl/qtt_pkg.sv
// Shared types, codes and constants of the quorum transaction tracker.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package qtt_pkg;

  // Table size default and cap on expiries reported per tick
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAX_RESULTS       = 16;
  localparam int CNT_W             = $clog2(MAX_RESULTS + 1);

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_QUORUM  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 1'd1;

  localparam logic [1:0] QUORUM_RESET  = 2'd2;
  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  // Operation codes; the spare code is taken and dropped without a result
  localparam logic [1:0] OP_ISSUE   = 2'd0;
  localparam logic [1:0] OP_REPLY   = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // Request kinds that matter to the verdict
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;

  // Result status codes
  localparam logic [3:0] ST_ISSUED    = 4'd0;
  localparam logic [3:0] ST_FULL      = 4'd1;
  localparam logic [3:0] ST_COUNTED   = 4'd2;
  localparam logic [3:0] ST_UNKNOWN   = 4'd3;
  localparam logic [3:0] ST_SUCCESS   = 4'd4;
  localparam logic [3:0] ST_FAILURE   = 4'd5;
  localparam logic [3:0] ST_NOVERDICT = 4'd6;
  localparam logic [3:0] ST_TIMEOUT   = 4'd7;
  localparam logic [3:0] ST_IDLE      = 4'd8;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] trans_id;
    logic [1:0]  request_kind;
    logic        reply_is_read;
    logic        reply_success;
    logic        reply_has_value;
    logic [15:0] now_time;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] done_id;
    logic [1:0]  done_kind;
    logic        last_result;
  } rsp_t;

  // Payload of one table slot
  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  kind;
    logic [15:0] stamp;
    logic [1:0]  replies;
  } entry_data_t;

  typedef struct packed {
    logic        valid;
    entry_data_t data;
  } entry_t;

  // What the head unit saw in the slot passing it this cycle
  typedef struct packed {
    logic        match;
    logic        free;
    logic        expire;
    logic [3:0]  status;
    logic [15:0] id;
    logic [1:0]  kind;
  } hit_t;

endpackage

`default_nettype wire

### rtl/qtt_cell.sv
// One slot of the rotating table: valid bit plus payload.
// Depends on qtt_pkg for the entry types.
`timescale 1ns / 1ps
`default_nettype none

module qtt_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  shift,
  input  wire                  load,
  input  qtt_pkg::entry_data_t load_data,
  input  qtt_pkg::entry_t      entry_in,
  output qtt_pkg::entry_t      entry
);

  logic                 valid;
  qtt_pkg::entry_data_t data;

  // Valid bit: cleared by reset, so the table starts empty
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (shift) begin
      valid <= entry_in.valid;
    end
  end

  // Payload takes the neighbour's slot on a shift, or a new transaction on a load
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= entry_in.data;
    end
  end

  assign entry.valid = valid;
  assign entry.data  = data;

endmodule

`default_nettype wire

### rtl/qtt_head.sv
// Head unit of the ring: examines the slot at cell 0 and gives its updated value.
// Depends on qtt_pkg for the item, entry and hit types.
`timescale 1ns / 1ps
`default_nettype none

module qtt_head (
  input  qtt_pkg::req_t   item,
  input  qtt_pkg::entry_t entry,
  input  wire [1:0]       quorum,
  input  wire [7:0]       timeout,
  input  wire             room,
  output qtt_pkg::entry_t entry_next,
  output qtt_pkg::hit_t   hit
);

  logic        match;
  logic        expired;
  logic [16:0] deadline;
  logic [2:0]  cnt;
  logic [3:0]  verdict;

  assign match    = entry.valid && (entry.data.id == item.trans_id);
  assign deadline = {1'b0, entry.data.stamp} + {9'd0, timeout};
  assign expired  = entry.valid && (deadline < {1'b0, item.now_time}) && room;
  assign cnt      = {1'b0, entry.data.replies} + 3'd1;

  // Verdict once the quorum is reached
  always_comb begin
    if (item.reply_is_read) begin
      verdict = item.reply_has_value ? qtt_pkg::ST_SUCCESS : qtt_pkg::ST_FAILURE;
    end else if (entry.data.kind == qtt_pkg::KIND_CREATE) begin
      verdict = qtt_pkg::ST_SUCCESS;
    end else if (entry.data.kind == qtt_pkg::KIND_READ) begin
      verdict = qtt_pkg::ST_NOVERDICT;
    end else begin
      verdict = item.reply_success ? qtt_pkg::ST_SUCCESS : qtt_pkg::ST_FAILURE;
    end
  end

  // Slot update and report per operation
  always_comb begin
    entry_next = entry;
    hit.match  = 1'b0;
    hit.free   = 1'b0;
    hit.expire = 1'b0;
    hit.status = qtt_pkg::ST_COUNTED;
    hit.id     = entry.data.id;
    hit.kind   = entry.data.kind;
    case (item.operation)
      qtt_pkg::OP_ISSUE: begin
        hit.match = match;
        hit.free  = !entry.valid;
      end
      qtt_pkg::OP_REPLY: begin
        hit.match = match;
        if (match) begin
          if (cnt < {1'b0, quorum}) begin
            entry_next.data.replies = cnt[1:0];
          end else begin
            entry_next.valid = 1'b0;
            hit.status       = verdict;
          end
        end
      end
      qtt_pkg::OP_TICK: begin
        if (expired) begin
          entry_next.valid = 1'b0;
          hit.expire       = 1'b1;
          hit.status       = qtt_pkg::ST_TIMEOUT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/quorum_transaction_tracker_core.sv
// Quorum transaction tracker: a ring of TABLE_ENTRIES slot cells rotating past one head unit.
// Each item takes one full rotation of the ring and then a closing step; the next transfer is
// taken only once the sequencer is back in idle, after the last result of the previous item
// is registered; the ring pauses while the output register holds an untaken result.
// One item is in work at a time. Reset (synchronous) holds ready low, empties the table at
// once and loads quorum 2, timeout 10; no sweep.
`timescale 1ns / 1ps
`default_nettype none

module quorum_transaction_tracker_core #(
  parameter int TABLE_ENTRIES = qtt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               req_valid,
  output logic                              req_ready,
  input  qtt_pkg::req_t                     req,
  output logic                              rsp_valid,
  input  wire                               rsp_ready,
  output qtt_pkg::rsp_t                     rsp,
  input  wire                               cfg_we,
  input  wire [qtt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire [qtt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;

  logic [1:0]               state;
  logic [IDX_W-1:0]         step;
  logic [IDX_W-1:0]         free_idx;
  logic                     free_found;
  logic                     found;
  logic                     held_valid;
  qtt_pkg::rsp_t            held;
  logic [qtt_pkg::CNT_W-1:0] n_exp;
  qtt_pkg::req_t            item;
  logic [1:0]               quorum;
  logic [7:0]               timeout;

  logic                     out_free;
  logic                     advance;
  logic                     finish;
  logic                     scan_push;
  logic                     room;
  qtt_pkg::rsp_t            fin;
  qtt_pkg::entry_t          ring [TABLE_ENTRIES];
  qtt_pkg::entry_t          head_next;
  qtt_pkg::hit_t            hit;
  qtt_pkg::entry_data_t     load_data;

  assign req_ready = (state == S_IDLE) && !rst;
  assign out_free  = !rsp_valid || rsp_ready;
  assign advance   = (state == S_SCAN) && out_free;
  assign finish    = (state == S_FINAL) && out_free;
  assign room      = n_exp < qtt_pkg::CNT_W'(qtt_pkg::MAX_RESULTS);
  assign scan_push = advance && hit.expire && held_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quorum  <= qtt_pkg::QUORUM_RESET;
      timeout <= qtt_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == qtt_pkg::REG_QUORUM) begin
        quorum <= cfg_data[1:0];
      end
      if (cfg_index == qtt_pkg::REG_TIMEOUT) begin
        timeout <= cfg_data;
      end
    end
  end

  // Head unit at cell 0
  qtt_head u_head (
    .item       (item),
    .entry      (ring[0]),
    .quorum     (quorum),
    .timeout    (timeout),
    .room       (room),
    .entry_next (head_next),
    .hit        (hit)
  );

  assign load_data.id      = item.trans_id;
  assign load_data.kind    = item.request_kind;
  assign load_data.stamp   = item.now_time;
  assign load_data.replies = 2'd0;

  // Ring of slot cells, each shifting towards cell 0; the head feeds the far end
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    qtt_pkg::entry_t nbr;
    logic            load;
    if (i == TABLE_ENTRIES - 1) begin : g_end
      assign nbr = head_next;
    end else begin : g_mid
      assign nbr = ring[i+1];
    end
    assign load = finish && (item.operation == qtt_pkg::OP_ISSUE) && !found &&
                  free_found && (free_idx == IDX_W'(i));
    qtt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (advance),
      .load      (load),
      .load_data (load_data),
      .entry_in  (nbr),
      .entry     (ring[i])
    );
  end

  // Sequencer: one rotation per item, then a closing step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          step <= '0;
          if (req_valid && (req.operation != qtt_pkg::OP_IGNORED)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (advance) begin
            step <= step + IDX_W'(1);
            if (step == LAST_STEP) begin
              state <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
  end

  // Bookkeeping gathered while the slots pass the head
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      held_valid <= 1'b0;
      n_exp      <= '0;
    end else if (req_valid && req_ready) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      held_valid <= 1'b0;
      n_exp      <= '0;
    end else if (advance) begin
      if (hit.match) begin
        found <= 1'b1;
      end
      if (hit.free && !free_found) begin
        free_found <= 1'b1;
      end
      if (hit.expire) begin
        held_valid <= 1'b1;
        n_exp      <= n_exp + qtt_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (hit.free && !free_found) begin
        free_idx <= step;
      end
      if ((item.operation == qtt_pkg::OP_REPLY) && hit.match) begin
        held <= '{status: hit.status, done_id: item.trans_id, done_kind: hit.kind,
                  last_result: 1'b0};
      end else if (hit.expire) begin
        held <= '{status: qtt_pkg::ST_TIMEOUT, done_id: hit.id, done_kind: hit.kind,
                  last_result: 1'b0};
      end
    end
  end

  // Closing result of the item
  always_comb begin
    fin = '{status: qtt_pkg::ST_IDLE, done_id: 16'd0, done_kind: 2'd0, last_result: 1'b1};
    case (item.operation)
      qtt_pkg::OP_ISSUE: begin
        fin.status    = (found || free_found) ? qtt_pkg::ST_ISSUED : qtt_pkg::ST_FULL;
        fin.done_id   = item.trans_id;
        fin.done_kind = item.request_kind;
      end
      qtt_pkg::OP_REPLY: begin
        if (found) begin
          fin = held;
        end else begin
          fin.status  = qtt_pkg::ST_UNKNOWN;
          fin.done_id = item.trans_id;
        end
        fin.last_result = 1'b1;
      end
      qtt_pkg::OP_TICK: begin
        if (held_valid) begin
          fin             = held;
          fin.last_result = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: closing result or an earlier expiry pushed out by a newer one
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish || scan_push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp <= fin;
    end else if (scan_push) begin
      rsp <= held;
    end
  end

  // Checks on the sequencer and result ordering
  a_exp_cap: assert property (@(posedge clk) disable iff (rst)
    n_exp <= qtt_pkg::CNT_W'(qtt_pkg::MAX_RESULTS))
    else $error("expiry count above limit");

  a_scan_push_tick: assert property (@(posedge clk) disable iff (rst)
    scan_push |-> (item.operation == qtt_pkg::OP_TICK) && (state == S_SCAN))
    else $error("mid-scan result outside a tick");

  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (advance && (step == LAST_STEP)) |=> (state == S_FINAL))
    else $error("rotation did not close");

  a_mid_not_last: assert property (@(posedge clk) disable iff (rst)
    scan_push |=> rsp_valid && !rsp.last_result)
    else $error("mid-scan result marked last");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    finish |=> (state == S_IDLE) && rsp_valid && rsp.last_result)
    else $error("closing step misbehaved");

endmodule

`default_nettype wire

### bench/quorum_transaction_tracker_core_tb.sv
// Self-checking bench for quorum_transaction_tracker_core: directed and random request,
// reply and tick transfers, predicted against a shadow copy of the transaction table.
// Depends on qtt_pkg and the core only.
`timescale 1ns / 1ps

module quorum_transaction_tracker_core_tb;

  localparam int SLOTS       = qtt_pkg::TABLE_ENTRIES_DEF;
  localparam int POOL        = 20;
  localparam int SETTLE      = 40;      // covers one full ring rotation with margin
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    qtt_pkg::req_t payload;
    logic          wait_drain;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  qtt_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  qtt_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [qtt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [qtt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the transaction table and registers
  logic        tab_valid [SLOTS];
  logic [15:0] tab_id [SLOTS];
  logic [1:0]  tab_kind [SLOTS];
  logic [15:0] tab_stamp [SLOTS];
  logic [1:0]  tab_replies [SLOTS];
  logic [1:0]  cfg_quorum = qtt_pkg::QUORUM_RESET;
  logic [7:0]  cfg_timeout = qtt_pkg::TIMEOUT_RESET;

  stim_t stim_q[$];
  qtt_pkg::rsp_t awaited_results[$];
  int    results_predicted = 0;
  int    results_seen = 0;
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_left = 0;
  logic  hold_start = 1'b0;
  int    cycle_count = 0;
  logic [15:0] id_pool [POOL];

  quorum_transaction_tracker_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40) begin
      $display("ERROR @%0t: %s: got %0h, want %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic qtt_pkg::rsp_t result_of(logic [3:0] st, logic [15:0] id,
                                              logic [1:0] kind, logic last);
    qtt_pkg::rsp_t r;
    r.status      = st;
    r.done_id     = id;
    r.done_kind   = kind;
    r.last_result = last;
    return r;
  endfunction

  // Works out the results of one accepted request and updates the shadow table
  function automatic int track_request(input qtt_pkg::req_t r);
    int   slot;
    int   free_slot;
    int   n;
    int   cnt;
    qtt_pkg::rsp_t held;
    logic [3:0] verdict;
    slot = -1;
    free_slot = -1;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tab_valid[i] && tab_id[i] == r.trans_id && slot < 0) slot = i;
      if (!tab_valid[i] && free_slot < 0) free_slot = i;
    end
    case (r.operation)
      qtt_pkg::OP_ISSUE: begin
        // a pending id is left alone but still reported as issued
        if (slot < 0 && free_slot < 0) begin
          awaited_results.push_back(result_of(qtt_pkg::ST_FULL, r.trans_id, r.request_kind,
                                              1'b1));
        end else begin
          if (slot < 0) begin
            tab_valid[free_slot]   = 1'b1;
            tab_id[free_slot]      = r.trans_id;
            tab_kind[free_slot]    = r.request_kind;
            tab_stamp[free_slot]   = r.now_time;
            tab_replies[free_slot] = 2'd0;
          end
          awaited_results.push_back(result_of(qtt_pkg::ST_ISSUED, r.trans_id, r.request_kind,
                                              1'b1));
        end
        return 1;
      end
      qtt_pkg::OP_REPLY: begin
        if (slot < 0) begin
          awaited_results.push_back(result_of(qtt_pkg::ST_UNKNOWN, r.trans_id, '0, 1'b1));
          return 1;
        end
        cnt = int'(tab_replies[slot]) + 1;
        if (cnt < int'(cfg_quorum)) begin
          tab_replies[slot] = cnt[1:0];
          awaited_results.push_back(result_of(qtt_pkg::ST_COUNTED, r.trans_id, tab_kind[slot],
                                              1'b1));
          return 1;
        end
        tab_valid[slot] = 1'b0;
        if (r.reply_is_read)
          verdict = r.reply_has_value ? qtt_pkg::ST_SUCCESS : qtt_pkg::ST_FAILURE;
        else if (tab_kind[slot] == qtt_pkg::KIND_CREATE) verdict = qtt_pkg::ST_SUCCESS;
        else if (tab_kind[slot] == qtt_pkg::KIND_READ) verdict = qtt_pkg::ST_NOVERDICT;
        else verdict = r.reply_success ? qtt_pkg::ST_SUCCESS : qtt_pkg::ST_FAILURE;
        awaited_results.push_back(result_of(verdict, r.trans_id, tab_kind[slot], 1'b1));
        return 1;
      end
      qtt_pkg::OP_TICK: begin
        // expiries in slot order; the final one carries the last flag
        for (int i = 0; i < SLOTS; i++) begin
          if (n < qtt_pkg::MAX_RESULTS && tab_valid[i] &&
              ({1'b0, tab_stamp[i]} + {9'd0, cfg_timeout}) < {1'b0, r.now_time}) begin
            if (n > 0) awaited_results.push_back(held);
            tab_valid[i] = 1'b0;
            held = result_of(qtt_pkg::ST_TIMEOUT, tab_id[i], tab_kind[i], 1'b0);
            n++;
          end
        end
        if (n == 0) begin
          awaited_results.push_back(result_of(qtt_pkg::ST_IDLE, '0, '0, 1'b1));
          return 1;
        end
        held.last_result = 1'b1;
        awaited_results.push_back(held);
        return n;
      end
      default: return 0;
    endcase
  endfunction

  // Driver: offers queued requests, records each transfer with the predictor
  always @(posedge clk) begin : drive
    int    n;
    stim_t upcoming;
    logic  drained;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      drained = (results_predicted == results_seen) && !(req_valid && req_ready);
      if (req_valid && req_ready) begin
        n = track_request(req);
        results_predicted <= results_predicted + n;
      end
      if (!req_valid || req_ready) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            (!stim_q[0].wait_drain || drained)) begin
          upcoming = stim_q.pop_front();
          req       <= upcoming.payload;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compares each result transfer with the oldest expectation
  always @(posedge clk) begin : collect
    qtt_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        results_seen <= results_seen + 1;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing expected, status", int'(rsp.status), 0);
        end else begin
          want = awaited_results.pop_front();
          if (rsp.status != want.status)
            report_mismatch("status", int'(rsp.status), int'(want.status));
          if (rsp.done_id != want.done_id)
            report_mismatch("done_id", int'(rsp.done_id), int'(want.done_id));
          if (rsp.done_kind != want.done_kind)
            report_mismatch("done_kind", int'(rsp.done_kind), int'(want.done_kind));
          if (rsp.last_result != want.last_result)
            report_mismatch("last_result", int'(rsp.last_result), int'(want.last_result));
        end
      end
      rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL quorum_transaction_tracker_core");
      $finish;
    end
  end

  task automatic offer(input logic [1:0] op, input logic [15:0] id, input logic [1:0] kind,
                       input logic rd, input logic ok, input logic val,
                       input logic [15:0] now, input logic drain);
    stim_t s;
    s.payload.operation       = op;
    s.payload.trans_id        = id;
    s.payload.request_kind    = kind;
    s.payload.reply_is_read   = rd;
    s.payload.reply_success   = ok;
    s.payload.reply_has_value = val;
    s.payload.now_time        = now;
    s.wait_drain              = drain;
    stim_q.push_back(s);
  endtask

  // Waits until every request is taken, every result is in and the ring has settled
  task automatic wait_quiet();
    @(negedge clk);
    while (stim_q.size() != 0 || req_valid || results_predicted != results_seen)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [qtt_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == qtt_pkg::REG_QUORUM) cfg_quorum = value[1:0];
    else cfg_timeout = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic over a small id pool so replies mostly find their entries
  task automatic queue_random(input int count);
    int produced;
    int pick;
    int clock_now;
    logic [1:0] op;
    logic [15:0] id;
    logic [15:0] now;
    produced = 0;
    clock_now = $urandom_range(50000);
    for (int j = 0; j < POOL; j++) id_pool[j] = 16'($urandom_range(65535));
    while (produced < count) begin
      pick = $urandom_range(99);
      id   = id_pool[$urandom_range(POOL - 1)];
      now  = clock_now[15:0];
      if (pick < 35) begin
        op = qtt_pkg::OP_ISSUE;
      end else if (pick < 80) begin
        op  = qtt_pkg::OP_REPLY;
        now = 16'($urandom_range(65535));
      end else if (pick < 94) begin
        op = qtt_pkg::OP_TICK;
      end else if (pick < 97) begin
        op  = ($urandom_range(1) != 0) ? qtt_pkg::OP_REPLY : qtt_pkg::OP_ISSUE;
        id  = 16'($urandom_range(65535));
        now = 16'($urandom_range(65535));
      end else begin
        op  = qtt_pkg::OP_IGNORED;
        id  = 16'($urandom_range(65535));
        now = 16'($urandom_range(65535));
      end
      offer(op, id, 2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
            1'($urandom_range(1)), now, produced == 20);
      if (op != qtt_pkg::OP_IGNORED) produced++;
      clock_now += $urandom_range(3);
      if ($urandom_range(39) == 0) clock_now += $urandom_range(300);
    end
  endtask

  initial begin
    int q_set [5]     = '{1, 3, 0, 2, 3};
    int t_set [5]     = '{0, 255, 3, 12, 1};
    int send_set [5]  = '{0, 56, 0, 35, 0};
    int stall_set [5] = '{0, 0, 56, 35, 0};
    for (int i = 0; i < SLOTS; i++) tab_valid[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: fill the table, ids 0000..FFFF, kinds cycling
    for (int i = 0; i < SLOTS; i++)
      offer(qtt_pkg::OP_ISSUE, 16'(16'h1111 * i), 2'(i % 4), 1'b0, 1'b0, 1'b0,
            (i == SLOTS - 1) ? 16'hFFF0 : 16'(i), 1'b0);
    offer(qtt_pkg::OP_ISSUE, 16'h3333, qtt_pkg::KIND_CREATE, 1'b0, 1'b0, 1'b0, 16'd500,
          1'b0);                                                             // already pending
    offer(qtt_pkg::OP_ISSUE, 16'hABCD, 2'd2, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0); // table full
    offer(qtt_pkg::OP_REPLY, 16'h1234, 2'd0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0); // unknown id
    // create resolves as success whatever the success bit says
    offer(qtt_pkg::OP_REPLY, 16'h0000, 2'd3, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0);
    offer(qtt_pkg::OP_REPLY, 16'h0000, 2'd3, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0);
    // plain replies to a read: no verdict
    offer(qtt_pkg::OP_REPLY, 16'h1111, 2'd0, 1'b0, 1'b1, 1'b1, 16'd0, 1'b0);
    offer(qtt_pkg::OP_REPLY, 16'h1111, 2'd0, 1'b0, 1'b1, 1'b1, 16'd0, 1'b0);
    // update follows the success bit: failure
    offer(qtt_pkg::OP_REPLY, 16'h2222, 2'd0, 1'b0, 1'b0, 1'b1, 16'd0, 1'b0);
    offer(qtt_pkg::OP_REPLY, 16'h2222, 2'd0, 1'b0, 1'b0, 1'b1, 16'd0, 1'b0);
    // delete with success
    offer(qtt_pkg::OP_REPLY, 16'h3333, 2'd0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0);
    offer(qtt_pkg::OP_REPLY, 16'h3333, 2'd0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0);
    // read replies without a value: failure
    offer(qtt_pkg::OP_REPLY, 16'h5555, 2'd0, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0);
    offer(qtt_pkg::OP_REPLY, 16'h5555, 2'd0, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0);
    offer(qtt_pkg::OP_TICK, 16'h0000, 2'd0, 1'b0, 1'b0, 1'b0, 16'd5, 1'b0);  // nothing expires
    offer(qtt_pkg::OP_TICK, 16'h0000, 2'd0, 1'b0, 1'b0, 1'b0, 16'd20, 1'b0); // several expire
    offer(qtt_pkg::OP_IGNORED, 16'hFFFF, 2'd3, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b0);
    offer(qtt_pkg::OP_TICK, 16'hFFFF, 2'd3, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b0); // clears the rest

    // Random phases, each under its own register setting and idling pattern
    for (int p = 0; p < 5; p++) begin
      wait_quiet();
      write_reg(qtt_pkg::REG_QUORUM, 8'(q_set[p]));
      write_reg(qtt_pkg::REG_TIMEOUT, 8'(t_set[p]));
      @(negedge clk);
      send_idle_pct  = send_set[p];
      recv_stall_pct = stall_set[p];
      if (p == 3) begin
        // receiver holds off while the sender keeps offering
        hold_start = 1'b1;
        @(negedge clk);
        hold_start = 1'b0;
      end
      queue_random(45);
    end

    wait_quiet();
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", awaited_results.size(), 0);
    if (mismatches == 0) begin
      $display("PASS quorum_transaction_tracker_core");
    end else begin
      $display("FAIL quorum_transaction_tracker_core");
    end
    $finish;
  end

endmodule
